@@ rtl/prfl_pkg.sv @@
// Package for the PCM ring FIFO with low-water event.
// Holds ring sizing, pointer widths, register indexes and the stage record type.
// No dependencies; used by pcm_ring_fifo_low_water.
package prfl_pkg;

    // Ring sizing: pointers count modulo twice the depth.
    localparam int RING_DEPTH = 1024;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int PTR_W      = $clog2(RING_DEPTH) + 1;
    localparam int CNT_W      = (PTR_W > 11) ? PTR_W : 11;

    localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_SPAN  = PTR_W'(2 * RING_DEPTH);

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 10;
    localparam int FREE_W   = 11;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_WATER   = 1'b1;

    // Request kinds carried on tuser.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Result fields known at accept time; the sample follows from the ring.
    typedef struct packed {
        logic              frame_accepted;
        logic              popped;
        logic              low_water_event;
        logic [FREE_W-1:0] free_slots;
    } stage_t;

endpackage

@@ rtl/pcm_ring_fifo_low_water.sv @@
// Top level of the PCM ring FIFO with low-water event.
// Depends on prfl_pkg for sizing, register indexes and the stage record.
//
// Usage:
//   s_* carries request words. s_tuser is the request kind (write frame or
//   read sample), s_tlast marks the last read of a consumer chunk, where the
//   low-water check happens. m_* carries one result word per request.
//   cfg_* writes stereo_mode (index 0) and low_water_level (index 1); it is
//   always ready and must only be used while the block is idle.
// Pipeline and throughput:
//   A request is registered in the stage record, then in the output
//   register, which drives the result word on m_*. One request is taken
//   per cycle while s_tready is high; the pointer update and the ring access
//   (one write port, one registered read port) finish in the accept cycle.
// Reset:
//   Pointers, the armed flag, the registers and the pipeline valid bits
//   clear. Ring contents are not cleared; a slot is never read unwritten.
// Stall:
//   A result held on m_* while m_tready is low stalls the pipeline stage
//   behind it; if that stage is empty, one more request is still taken;
//   after that s_tready drops until the result word is taken.
module pcm_ring_fifo_low_water
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Request words.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] left_sample, [31:16] right_sample, [32] event_room, [39:33] zero
    input  logic [prfl_pkg::IN_W-1:0]          s_tdata,
    // [0] req_type
    input  logic                               s_tuser,
    // chunk_end
    input  logic                               s_tlast,
    // Result words.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] frame_accepted, [16:1] out_sample, [17] out_valid,
    // [18] low_water_event, [29:19] free_slots, [31:30] zero
    output logic [prfl_pkg::OUT_W-1:0]         m_tdata,
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prfl_pkg::LEVEL_W-1:0]       cfg_data
);

    import prfl_pkg::*;

    // Configuration and ring control state.
    logic                stereo_mode_reg;
    logic [LEVEL_W-1:0]  low_water_level_reg;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                armed_reg, armed_next;

    // Pipeline state.
    logic                s1_valid_reg;
    stage_t              s1_reg, s1_next;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    // Ring storage.
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

    // Request decode.
    logic                  accept;
    logic                  is_read;
    logic signed [SAMPLE_W-1:0] left_s, right_s;
    logic                  event_room;
    logic                  out_free;
    logic                  s1_move;

    // Ring arithmetic.
    logic [PTR_W-1:0]      buffered, buffered_after;
    logic                  ring_full, ring_empty;
    logic                  do_write, do_pop;
    logic [SLOT_W-1:0]     wr_slot, rd_slot;
    logic [PTR_W-1:0]      wr_slot_full, rd_slot_full;
    logic signed [SAMPLE_W:0] pair_sum;
    logic signed [SAMPLE_W:0] pair_avg;
    logic [SAMPLE_W-1:0]   store_value;
    logic [CNT_W-1:0]      free_count;
    logic                  low_hit;

    assign cfg_ready = 1'b1;

    assign left_s     = s_tdata[SAMPLE_W-1:0];
    assign right_s    = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign event_room = s_tdata[2*SAMPLE_W];
    assign is_read    = (s_tuser == REQ_READ);

    // Handshake: the stage register drains into the output register.
    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // Fill level from the two pointers, modulo twice the depth.
    always_comb
    begin
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            buffered = wr_ptr_reg - rd_ptr_reg;
        end
        else
        begin
            buffered = wr_ptr_reg - rd_ptr_reg + PTR_SPAN;
        end
    end

    assign ring_full  = (buffered == PTR_DEPTH);
    assign ring_empty = (buffered == '0);
    assign do_write   = accept && !is_read && !ring_full;
    assign do_pop     = accept && is_read && !ring_empty;

    // Slot addresses fold the pointer back into the ring.
    assign wr_slot_full = (wr_ptr_reg >= PTR_DEPTH) ? wr_ptr_reg - PTR_DEPTH : wr_ptr_reg;
    assign rd_slot_full = (rd_ptr_reg >= PTR_DEPTH) ? rd_ptr_reg - PTR_DEPTH : rd_ptr_reg;
    assign wr_slot      = wr_slot_full[SLOT_W-1:0];
    assign rd_slot      = rd_slot_full[SLOT_W-1:0];

    // Stereo average, truncated toward zero.
    assign pair_sum    = (SAMPLE_W+1)'(left_s) + (SAMPLE_W+1)'(right_s);
    assign pair_avg    = (pair_sum + (SAMPLE_W+1)'(pair_sum[SAMPLE_W])) >>> 1;
    assign store_value = stereo_mode_reg ? pair_avg[SAMPLE_W-1:0] : left_s;

    // Pointer updates, low-water check and result fields.
    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        armed_next     = armed_reg;
        buffered_after = buffered;
        if (do_write)
        begin
            wr_ptr_next    = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            buffered_after = buffered + 1'b1;
            armed_next     = (low_water_level_reg != '0);
        end
        if (do_pop)
        begin
            rd_ptr_next    = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            buffered_after = buffered - 1'b1;
        end
        low_hit = accept && is_read && s_tlast && armed_reg
                  && (CNT_W'(buffered_after) <= CNT_W'(low_water_level_reg));
        if (low_hit && event_room)
        begin
            armed_next = 1'b0;
        end
        free_count                = CNT_W'(RING_DEPTH) - CNT_W'(buffered_after);
        s1_next.frame_accepted    = do_write;
        s1_next.popped            = do_pop;
        s1_next.low_water_event   = low_hit;
        s1_next.free_slots        = free_count[FREE_W-1:0];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_mode_reg     <= 1'b0;
            low_water_level_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STEREO_MODE: stereo_mode_reg     <= cfg_data[0];
                REG_LOW_WATER:   low_water_level_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Pointers and armed flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            armed_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            armed_reg  <= armed_next;
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            ring_mem[wr_slot] <= store_value;
        end
        if (do_pop)
        begin
            rd_data_reg <= ring_mem[rd_slot];
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload: the stage record, then the packed result word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            out_data_reg <= {
                {(OUT_W - FREE_W - SAMPLE_W - 3){1'b0}},
                s1_reg.free_slots,
                s1_reg.low_water_event,
                s1_reg.popped,
                (s1_reg.popped ? rd_data_reg : {SAMPLE_W{1'b0}}),
                s1_reg.frame_accepted
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The fill level never passes the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buffered <= PTR_DEPTH)
        else $error("ring fill level exceeds depth");

    // A stored frame and a popped sample never share one result.
    a_write_or_pop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_reg.frame_accepted && s1_reg.popped))
        else $error("result marks both a stored frame and a popped sample");

    // After a stored frame the flag follows whether a level is set.
    a_arm_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        do_write && !low_hit |=> armed_reg == ($past(low_water_level_reg) != '0))
        else $error("armed flag wrong after stored frame");

    // An event is only raised for a read at a chunk end.
    a_event_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_next.low_water_event |-> is_read && s_tlast)
        else $error("low-water event raised outside a chunk-end read");

    // A popped slot leaves the ring one entry emptier.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> buffered == $past(buffered) - 1'b1)
        else $error("pop did not reduce fill level");

endmodule
